// File: rtl/plu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plu_pkg: shared definitions for the positional list engine
// Command op codes, result status codes and fixed field widths.
// ----------------------------------------------------------------------------
package plu_pkg;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int ITEM_W   = 6;

	localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_POS  = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
	localparam logic [OP_W-1:0] OP_LIST     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

endpackage
`default_nettype wire

// File: rtl/plu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plu_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module plu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/plu_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plu_step: shared index step unit
// Steps the working index up or down by one and compares against the bound.
// ----------------------------------------------------------------------------
module plu_step #(
	parameter int IW = 4
) (
	input  wire logic [IW-1:0] idx,
	input  wire logic [IW-1:0] bound,
	input  wire logic          up,
	output logic      [IW-1:0] nxt,
	output logic               hit_nxt,
	output logic               at_end
);

	assign nxt     = up ? (idx + 1'b1) : (idx - 1'b1);
	assign hit_nxt = (nxt == bound);
	assign at_end  = (idx == bound);

endmodule
`default_nettype wire

// File: rtl/positional_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_unit: bounded ordered list of signed 32-bit values
// Insert, append, remove at a position and list-all over a RAM-held list.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Commands that fail
// a check (full, bad position, empty) do not raise busy: the status comes
// on done in the next cycle. An insert at position p into a list of n
// entries moves n-p entries and a remove at p moves n-p-1, holding busy
// meanwhile, since each moved entry needs one RAM read and one RAM write
// stepped by a single index unit. List-all reads each entry, then presents
// it, before it reads the next. Every result is shown on done for exactly
// one cycle and the receiver cannot stall it; last marks a command's final
// transfer.
module positional_list_engine_unit
	import plu_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [OP_W-1:0]            op,
	input  wire logic signed [VALUE_W-1:0]  value,
	input  wire logic [POS_W-1:0]           position,
	output logic                            done,
	output logic [STATUS_W-1:0]             status,
	output logic signed [VALUE_W-1:0]       item_value,
	output logic [ITEM_W-1:0]               item_index,
	output logic                            last
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_WR   = 6'b000100,
		S_FIN  = 6'b001000,
		S_LRD  = 6'b010000,
		S_LOUT = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [IW-1:0]       idx_q, idx_d;
	logic [IW-1:0]       bound_q, bound_d;
	logic                up_q, up_d;
	logic                ins_q, ins_d;
	logic [VALUE_W-1:0]  val_q, val_d;

	logic                emit;
	logic [STATUS_W-1:0] st_d;
	logic [VALUE_W-1:0]  iv_d;
	logic [ITEM_W-1:0]   ii_d;
	logic                last_d;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  item_value_q;
	logic [ITEM_W-1:0]   item_index_q;
	logic                last_q;

	logic [IW-1:0]       nxt;
	logic                hit_nxt;
	logic                at_end;

	logic                rd_en, wr_en;
	logic [IW-1:0]       rd_addr, wr_addr;
	logic [VALUE_W-1:0]  wr_data, rd_data;

	logic                accept;
	logic                is_ins;
	logic                full;
	logic [POS_W-1:0]    cnt8;
	logic [POS_W-1:0]    eff_pos;

	plu_step #(.IW(IW)) u_step (
		.idx     (idx_q),
		.bound   (bound_q),
		.up      (up_q),
		.nxt     (nxt),
		.hit_nxt (hit_nxt),
		.at_end  (at_end)
	);

	plu_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign is_ins = (op == OP_INS_HEAD) || (op == OP_INS_POS) || (op == OP_INS_TAIL);
	assign full   = (count_q == CW'(CAPACITY));
	assign cnt8   = POS_W'(count_q);

	always_comb begin
		case (op)
			OP_INS_HEAD: eff_pos = '0;
			OP_INS_TAIL: eff_pos = cnt8;
			default:     eff_pos = position;
		endcase
	end

	// Inserts move entries downward from the tail, removes move them upward
	// from the hole; the step unit walks the index toward the bound.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d   = idx_q;
		bound_d = bound_q;
		up_d    = up_q;
		ins_d   = ins_q;
		val_d   = val_q;
		emit    = 1'b0;
		st_d    = ST_OK;
		iv_d    = '0;
		ii_d    = '0;
		last_d  = 1'b1;
		rd_en   = 1'b0;
		rd_addr = nxt;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_ins) begin
						if (full) begin
							emit = 1'b1;
							st_d = ST_FULL;
						end else if (eff_pos > cnt8) begin
							emit = 1'b1;
							st_d = ST_BADPOS;
						end else begin
							idx_d   = IW'(count_q);
							bound_d = IW'(eff_pos);
							up_d    = 1'b0;
							ins_d   = 1'b1;
							val_d   = value;
							state_d = (eff_pos == cnt8) ? S_FIN : S_RD;
						end
					end else if (op == OP_REMOVE) begin
						if (count_q == '0) begin
							emit = 1'b1;
							st_d = ST_EMPTY;
						end else if (position >= cnt8) begin
							emit = 1'b1;
							st_d = ST_BADPOS;
						end else begin
							idx_d   = IW'(position);
							bound_d = IW'(count_q - 1'b1);
							up_d    = 1'b1;
							ins_d   = 1'b0;
							state_d = (({1'b0, position} + 9'd1) == 9'(count_q)) ?
								S_FIN : S_RD;
						end
					end else if (op == OP_LIST) begin
						if (count_q == '0) begin
							emit = 1'b1;
							st_d = ST_EMPTY;
						end else begin
							idx_d   = '0;
							bound_d = IW'(count_q - 1'b1);
							up_d    = 1'b1;
							state_d = S_LRD;
						end
					end
				end
			end
			S_RD: begin
				rd_en   = 1'b1;
				rd_addr = nxt;
				state_d = S_WR;
			end
			S_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = rd_data;
				idx_d   = nxt;
				state_d = hit_nxt ? S_FIN : S_RD;
			end
			S_FIN: begin
				if (ins_q) begin
					wr_en   = 1'b1;
					wr_data = val_q;
					count_d = count_q + 1'b1;
				end else begin
					count_d = count_q - 1'b1;
				end
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_LRD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
				state_d = S_LOUT;
			end
			S_LOUT: begin
				emit   = 1'b1;
				iv_d   = rd_data;
				ii_d   = ITEM_W'(idx_q);
				last_d = at_end;
				if (at_end) begin
					state_d = S_IDLE;
				end else begin
					idx_d   = nxt;
					state_d = S_LRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		bound_q <= bound_d;
		up_q    <= up_d;
		ins_q   <= ins_d;
		val_q   <= val_d;
		if (emit) begin
			status_q     <= st_d;
			item_value_q <= iv_d;
			item_index_q <= ii_d;
			last_q       <= last_d;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign item_value = item_value_q;
	assign item_index = item_index_q;
	assign last       = last_q;

endmodule
`default_nettype wire

// File: rtl/plu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plu_checker: port-level checks for the positional list engine
// Watches result timing and result contents; bound to the top level.
// ----------------------------------------------------------------------------
module plu_checker
	import plu_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic [STATUS_W-1:0]   status,
	input wire logic [VALUE_W-1:0]    item_value,
	input wire logic [ITEM_W-1:0]     item_index,
	input wire logic                  last
);

	// A listing that is not finished keeps the block busy.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy)
		else $error("non-final transfer while not busy");

	// A non-final listed entry is followed by a gap in done, then the next entry.
	a_list_cadence: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> !done ##1 done)
		else $error("list transfer cadence broken");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> last && (item_value == '0) && (item_index == '0))
		else $error("error status must be a single zeroed transfer");

	// Leaving busy always coincides with the final transfer of the command.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done && last)
		else $error("command ended without a final transfer");

endmodule

bind positional_list_engine_unit plu_checker u_plu_checker (.*);
`default_nettype wire
